FILE: sv/dll_pkg.sv
`timescale 1ns / 1ps
package dll_pkg;
  localparam int Depth     = 64;
  localparam int DataWidth = 32;
  localparam int IdxW      = $clog2(Depth);
  localparam int CntW      = $clog2(Depth + 1);
  // node word: {value, next, prev}
  localparam int NodeW     = DataWidth + 2 * IdxW;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ERASE  = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOMATCH   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_CHK,
    S_PATCH_RD,
    S_PATCH_WR,
    S_FRONT_RD,
    S_BACK_RD,
    S_ENDS_CHK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [DataWidth-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [DataWidth-1:0] popped_value;
    logic [CntW-1:0]      match_count;
    logic                 erased_count;
    logic [CntW-1:0]      node_total;
    logic [DataWidth-1:0] front_value;
    logic [DataWidth-1:0] back_value;
    logic                 is_empty;
  } rsp_t;
endpackage

FILE: sv/dll_if.sv
`timescale 1ns / 1ps
interface dll_req_if import dll_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dll_rsp_if import dll_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/dll_ram.sv
`timescale 1ns / 1ps
module dll_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: sv/doubly_linked_list_engine.sv
`timescale 1ns / 1ps
// Operations: an append to an empty list, an append when full and any other operation on an
//   empty list need no walk or patch; other appends patch the old tail and removes read the
//   head node; count and an erase without a match walk the nodes, and an erase that hits walks
//   to its list position and then patches each neighbor link with a read and a write.
// Throughput: one word in flight, set by the walk over the single node memory read port
//   and the read-modify-write of links. Reset: async active low; list empty, all nodes free,
//   node memory not cleared.
module doubly_linked_list_engine import dll_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dll_req_if.sink   req,
  dll_rsp_if.source rsp
);
  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [IdxW-1:0] np_q, np_d, nq_q, nq_d;
  logic [CntW-1:0] cnt_q, cnt_d, walk_q, walk_d, match_q, match_d, walk_nxt;
  logic [Depth-1:0] free_q, free_d;
  status_e status_q, status_d;
  logic [DataWidth-1:0] popped_q, popped_d, front_q, front_d, back_q, back_d;
  logic erased_q, erased_d;
  // pending neighbor patches: [0] next of prev node, [1] prev of next node
  logic [1:0] fix_q, fix_d;

  // node RAM port
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [NodeW-1:0] wdata, rdata;
  logic [DataWidth-1:0] rd_val;
  logic [IdxW-1:0] rd_next, rd_prev;

  logic accept, hit, last;
  logic [IdxW-1:0] free_idx;

  dll_ram #(.Width(NodeW), .Depth(Depth)) u_node (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
  assign {rd_val, rd_next, rd_prev} = rdata;

  // lowest free node
  always_comb begin
    free_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) if (free_q[i]) free_idx = IdxW'(i);
  end

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_OUT);
  assign accept    = req.valid && req.ready;
  // walk: rdata holds the node at cur_q; the next node is read in the same cycle
  assign walk_nxt  = walk_q + 1'b1;
  assign hit       = (rd_val == req_q.value);
  assign last      = (walk_nxt == cnt_q);

  always_comb begin
    rsp.data.status       = status_q;
    rsp.data.popped_value = popped_q;
    rsp.data.match_count  = match_q;
    rsp.data.erased_count = erased_q;
    rsp.data.node_total   = cnt_q;
    rsp.data.front_value  = front_q;
    rsp.data.back_value   = back_q;
    rsp.data.is_empty     = (cnt_q == '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        unique case (op_e'(req.data.opcode))
          OP_APPEND: state_d = (cnt_q != '0 && cnt_q != CntW'(Depth)) ? S_PATCH_WR
                                                                      : S_FRONT_RD;
          OP_REMOVE, OP_ERASE, OP_COUNT:
            state_d = (cnt_q == '0) ? S_FRONT_RD : S_WALK_CHK;
          default: state_d = S_FRONT_RD;
        endcase
      end
      S_WALK_CHK: begin
        unique case (op_e'(req_q.opcode))
          OP_ERASE: begin
            if (hit) state_d = (cur_q != head_q || cur_q != tail_q) ? S_PATCH_RD : S_FRONT_RD;
            else if (last) state_d = S_FRONT_RD;
          end
          OP_COUNT: if (last) state_d = S_FRONT_RD;
          default:  state_d = S_FRONT_RD;
        endcase
      end
      S_PATCH_RD: state_d = S_PATCH_WR;
      // one patch left after this write only when both were pending
      S_PATCH_WR: state_d = (fix_q[0] && fix_q[1]) ? S_PATCH_RD : S_FRONT_RD;
      S_FRONT_RD: state_d = S_BACK_RD;
      S_BACK_RD:  state_d = S_ENDS_CHK;
      S_ENDS_CHK: state_d = S_OUT;
      S_OUT:      if (rsp.ready) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d = req_q; head_d = head_q; tail_d = tail_q; cur_d = cur_q; cnt_d = cnt_q;
    walk_d = walk_q; match_d = match_q; free_d = free_q; status_d = status_q;
    popped_d = popped_q; front_d = front_q; back_d = back_q; erased_d = erased_q;
    fix_d = fix_q; np_d = np_q; nq_d = nq_q;
    we = 1'b0; waddr = cur_q; wdata = '0; raddr = cur_q;
    unique case (state_q)
      S_IDLE: if (accept) begin
        req_d = req.data;
        status_d = ST_OK; popped_d = '0; match_d = '0; erased_d = 1'b0;
        walk_d = '0; cur_d = head_q; raddr = head_q; fix_d = 2'b00;
        unique case (op_e'(req.data.opcode))
          OP_APPEND: begin
            if (cnt_q == CntW'(Depth)) status_d = ST_FULL;
            else begin
              // new node goes to the lowest free slot as the tail
              we = 1'b1; waddr = free_idx;
              wdata = {req.data.value, IdxW'(0),
                       (cnt_q == '0) ? IdxW'(0) : tail_q};
              free_d[free_idx] = 1'b0;
              if (cnt_q == '0) head_d = free_idx;
              else begin
                // old tail needs its next link: read it now, write next cycle
                fix_d = 2'b01; np_d = tail_q; nq_d = free_idx; raddr = tail_q;
              end
              tail_d = free_idx; cnt_d = cnt_q + 1'b1;
            end
          end
          OP_REMOVE: if (cnt_q == '0) status_d = ST_UNDERFLOW;
          OP_ERASE:  if (cnt_q == '0) status_d = ST_NOMATCH;
          OP_COUNT: ;
          default: ;
        endcase
      end
      S_WALK_CHK: begin
        unique case (op_e'(req_q.opcode))
          OP_REMOVE: begin
            popped_d = rd_val; free_d[cur_q] = 1'b1; cnt_d = cnt_q - 1'b1;
            head_d = rd_next;
            if (cnt_q == CntW'(1)) begin head_d = '0; tail_d = '0; end
          end
          OP_ERASE: begin
            if (hit) begin
              erased_d = 1'b1; free_d[cur_q] = 1'b1; cnt_d = cnt_q - 1'b1;
              np_d = rd_prev; nq_d = rd_next;
              fix_d = {cur_q != tail_q, cur_q != head_q};
              if (cur_q == head_q) head_d = rd_next;
              if (cur_q == tail_q) tail_d = rd_prev;
              if (cnt_q == CntW'(1)) begin head_d = '0; tail_d = '0; end
            end else if (last) begin
              status_d = ST_NOMATCH;
            end else begin
              cur_d = rd_next; walk_d = walk_nxt; raddr = rd_next;
            end
          end
          OP_COUNT: begin
            if (hit) match_d = match_q + 1'b1;
            cur_d = rd_next; walk_d = walk_nxt; raddr = rd_next;
          end
          default: ;
        endcase
      end
      S_PATCH_RD: raddr = fix_q[0] ? np_q : nq_q;
      S_PATCH_WR: begin
        // rdata holds the neighbor read in the previous cycle
        we = 1'b1;
        if (fix_q[0]) begin
          waddr = np_q; wdata = {rd_val, nq_q, rd_prev};
          fix_d[0] = 1'b0;
        end else begin
          waddr = nq_q; wdata = {rd_val, rd_next, np_q};
          fix_d[1] = 1'b0;
        end
      end
      S_FRONT_RD: raddr = head_q;
      S_BACK_RD: begin raddr = tail_q; front_d = (cnt_q == '0) ? '0 : rd_val; end
      S_ENDS_CHK: back_d = (cnt_q == '0) ? '0 : rd_val;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; req_q <= '0; head_q <= '0; tail_q <= '0; cur_q <= '0;
      cnt_q <= '0; walk_q <= '0; match_q <= '0; free_q <= '1; status_q <= ST_OK;
      popped_q <= '0; front_q <= '0; back_q <= '0; erased_q <= 1'b0;
      fix_q <= '0; np_q <= '0; nq_q <= '0;
    end else begin
      state_q <= state_d; req_q <= req_d; head_q <= head_d; tail_q <= tail_d;
      cur_q <= cur_d; cnt_q <= cnt_d; walk_q <= walk_d; match_q <= match_d;
      free_q <= free_d; status_q <= status_d; popped_q <= popped_d;
      front_q <= front_d; back_q <= back_d; erased_q <= erased_d;
      fix_q <= fix_d; np_q <= np_d; nq_q <= nq_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(~free_q) == int'(cnt_q)))
    else $error("free mask disagrees with count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == '0 && tail_q == '0))
    else $error("empty list with stale ends");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
    else $error("result dropped or changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid)
    else $error("input taken with result pending");
endmodule

FILE: tb/doubly_linked_list_engine_test.sv
`timescale 1ns / 1ps
module doubly_linked_list_engine_test import dll_pkg::*; ();

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dll_req_if req_ch ();
  dll_rsp_if rsp_ch ();

  doubly_linked_list_engine i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .rsp   (rsp_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: the list is kept as a queue of (node, value) in list order.
  // Node numbers only matter for lowest-free allocation.
  logic [DataWidth-1:0] list_vals[$];
  logic [Depth-1:0]     node_busy;
  int                   list_nodes[$];

  req_t pending_words[$];
  rsp_t expected_rsps[$];
  int   errors = 0;

  function automatic rsp_t predict_list_op(req_t w);
    rsp_t r;
    int   n;
    int   hit;
    r = '0;
    case (op_e'(w.opcode))
      OP_APPEND: begin
        if (list_vals.size() >= Depth) begin
          r.status = ST_FULL;
        end else begin
          n = 0;
          while (node_busy[n]) n++;
          node_busy[n] = 1'b1;
          list_nodes = {list_nodes, n};
          list_vals  = {list_vals, w.value};
        end
      end
      OP_REMOVE: begin
        if (list_vals.size() == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.popped_value = list_vals[0];
          list_vals.delete(0);
          node_busy[list_nodes[0]] = 1'b0;
          list_nodes.delete(0);
        end
      end
      OP_ERASE: begin
        hit = -1;
        foreach (list_vals[k]) if (hit < 0 && list_vals[k] == w.value) hit = k;
        if (hit < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          node_busy[list_nodes[hit]] = 1'b0;
          list_nodes.delete(hit);
          list_vals.delete(hit);
          r.erased_count = 1'b1;
        end
      end
      default: begin
        foreach (list_vals[k]) if (list_vals[k] == w.value) r.match_count = r.match_count + 1'b1;
      end
    endcase
    r.node_total = CntW'(list_vals.size());
    r.is_empty   = (list_vals.size() == 0);
    if (list_vals.size() != 0) begin
      r.front_value = list_vals[0];
      r.back_value  = list_vals[$];
    end
    return r;
  endfunction

  // Short gaps mostly, a long one now and then.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Driver
  int drv_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      drv_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps = {expected_rsps, predict_list_op(req_ch.data)};
        pending_words.delete(0);
        drv_gap = pick_gap();
      end
      if (drv_gap > 0) begin
        drv_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_words[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor, with random stalls on ready
  int mon_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      mon_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %p", $time, rsp_ch.data);
        end else begin
          rsp_t e;
          e = expected_rsps[0];
          expected_rsps.delete(0);
          if (e !== rsp_ch.data) begin
            errors++;
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp_ch.data);
          end
        end
        mon_gap = pick_gap();
      end
      if (mon_gap > 0) begin
        mon_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_word(op_e op, logic [DataWidth-1:0] v);
    req_t w;
    w.opcode = op;
    w.value  = v;
    pending_words = {pending_words, w};
  endtask

  // Values drawn from a small pool so erase and count find matches.
  function automatic logic [DataWidth-1:0] pool_value();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 7) ^ {DataWidth{$urandom_range(0, 1) == 1}};
  endfunction

  initial begin
    node_busy = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list cases, extremes, every operation.
    queue_word(OP_REMOVE, '0);
    queue_word(OP_ERASE, 32'h5);
    queue_word(OP_COUNT, '1);
    queue_word(OP_APPEND, '0);
    queue_word(OP_APPEND, '0);
    queue_word(OP_APPEND, '1);
    queue_word(OP_COUNT, '0);
    queue_word(OP_ERASE, 32'h1234);
    queue_word(OP_ERASE, '1);     // tail erase
    queue_word(OP_ERASE, '0);     // head erase
    queue_word(OP_REMOVE, '0);    // pop last node
    queue_word(OP_APPEND, 32'hA5A5_5A5A);
    queue_word(OP_APPEND, 32'h1);
    queue_word(OP_APPEND, 32'h2);
    queue_word(OP_ERASE, 32'h1);  // middle erase
    queue_word(OP_REMOVE, '0);
    queue_word(OP_REMOVE, '0);

    // Random: fill to full, overflow, drain, with mixed traffic in between.
    for (int i = 0; i < 900; i++) begin
      int p;
      p = $urandom_range(0, 99);
      if (i >= 150 && i < 240) p = 0;        // drive toward full
      if (i >= 500 && i < 590) p = 50;       // drain
      if (p < 45)      queue_word(OP_APPEND, pool_value());
      else if (p < 65) queue_word(OP_REMOVE, $urandom());
      else if (p < 82) queue_word(OP_ERASE, pool_value());
      else             queue_word(OP_COUNT, pool_value());
    end

    wait (pending_words.size() == 0 && expected_rsps.size() == 0);
    repeat (2 * Depth + 100) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: a bound far above the time all queued words need, stalls included.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
